// ===== src/ilp_pkg.sv =====
`default_nettype none

package ilp_pkg;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CASE_BIT = 8'h20;
   localparam logic [7:0] HEX_BASE = 8'h61 - 8'd10;

   localparam logic [1:0] KIND_UNSIGNED = 2'd0;
   localparam logic [1:0] KIND_PREFIX   = 2'd2;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DIGIT     = 2'd1,
      ST_HEX_DIGIT = 2'd2,
      ST_OCT_DIGIT = 2'd3
   } status_type;

   typedef struct packed {
      logic       is_dec;
      logic       is_oct;
      logic       is_hex;
      logic [3:0] digit;
   } char_class_type;

endpackage

`default_nettype wire

// ===== src/ilp_char_class.sv =====
`default_nettype none

module ilp_char_class
   import ilp_pkg::*;
(
   input  wire logic [7:0]     ch,
   output char_class_type      cls
);

   logic [7:0] dec_off;
   logic [7:0] alpha_off;
   logic [7:0] hex_off;

   always_comb begin
      dec_off    = ch - CH_ZERO;
      alpha_off  = (ch | CASE_BIT) - 8'h61;
      hex_off    = (ch | CASE_BIT) - HEX_BASE;
      cls.is_dec = dec_off < 8'd10;
      cls.is_oct = dec_off < 8'd8;
      cls.is_hex = cls.is_dec || (alpha_off < 8'd6);
      cls.digit  = cls.is_dec ? dec_off[3:0] : hex_off[3:0];
   end

endmodule

`default_nettype wire

// ===== src/integer_literal_parser.sv =====
// Integer literal parser. Characters arrive one per word on the req_ channel; req_type picks
// the literal kind on the first character of each literal (0 unsigned decimal, 1 signed
// decimal, 2 or 3 signed with optional 0x hex or 0o octal prefix). The character that cannot
// continue a literal ends it, is consumed, and produces one rsp_ word: the value wrapped to
// VALUE_WIDTH bits and sign-extended to 64 (zero on an error status), a status, and that
// character. Each digit is a single multiply-by-constant-and-add step on the accumulator, so
// one character can be taken every cycle while req_ready is high. The result word is valid on
// the cycle after the ending character is taken. It sits in one output register, and
// req_ready stays low while that word waits and rsp_ready is low.

`default_nettype none

module integer_literal_parser
   import ilp_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [7:0]         req_ch,
   input  wire logic [1:0]         req_type,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [63:0] rsp_value,
   output      logic [1:0]         rsp_status,
   output      logic [7:0]         rsp_end_char
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_SIGN, PH_ZERO, PH_DEC, PH_HEXF, PH_HEX, PH_OCTF, PH_OCT
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   negative_ff, negative_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [1:0]             kind_ff, kind_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [63:0]     value_ff, value_in;
   status_type             status_ff, status_in;
   logic [7:0]             end_char_ff, end_char_in;

   char_class_type         cls;
   logic                   accept;
   logic                   emit;
   status_type             emit_status;
   logic [VALUE_WIDTH-1:0] digit_ext;
   logic [VALUE_WIDTH-1:0] acc_dec;
   logic [VALUE_WIDTH-1:0] acc_hex;
   logic [VALUE_WIDTH-1:0] acc_oct;
   logic [VALUE_WIDTH-1:0] mag;
   logic [1:0]             kind_cur;

   ilp_char_class u_char_class (
      .ch  (req_ch),
      .cls (cls)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign digit_ext = VALUE_WIDTH'(cls.digit);
   assign acc_dec   = (acc_ff << 3) + (acc_ff << 1) + digit_ext;
   assign acc_hex   = (acc_ff << 4) + digit_ext;
   assign acc_oct   = (acc_ff << 3) + digit_ext;
   assign mag       = negative_ff ? (~acc_ff + 1'b1) : acc_ff;
   assign kind_cur  = (phase_ff == PH_IDLE) ? req_type : kind_ff;

   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      kind_in     = kind_ff;
      emit        = 1'b0;
      emit_status = ST_OK;
      unique case (phase_ff)
         PH_IDLE, PH_SIGN: begin
            kind_in = kind_cur;
            if (phase_ff == PH_IDLE && req_type != KIND_UNSIGNED &&
                (req_ch == CH_PLUS || req_ch == CH_MINUS)) begin
               negative_in = (req_ch == CH_MINUS);
               phase_in    = PH_SIGN;
            end else if (cls.is_dec) begin
               acc_in   = digit_ext;
               phase_in = (kind_cur >= KIND_PREFIX && cls.digit == 4'd0) ? PH_ZERO : PH_DEC;
            end else begin
               emit        = 1'b1;
               emit_status = ST_DIGIT;
            end
         end
         PH_ZERO: begin
            if (req_ch == CH_X) begin
               phase_in = PH_HEXF;
            end else if (req_ch == CH_O) begin
               phase_in = PH_OCTF;
            end else if (cls.is_dec) begin
               acc_in   = acc_dec;
               phase_in = PH_DEC;
            end else begin
               emit = 1'b1;
            end
         end
         PH_DEC: begin
            if (cls.is_dec) begin
               acc_in = acc_dec;
            end else begin
               emit = 1'b1;
            end
         end
         PH_HEXF, PH_HEX: begin
            if (cls.is_hex) begin
               acc_in   = acc_hex;
               phase_in = PH_HEX;
            end else begin
               emit        = 1'b1;
               emit_status = (phase_ff == PH_HEXF) ? ST_HEX_DIGIT : ST_OK;
            end
         end
         PH_OCTF, PH_OCT: begin
            if (cls.is_oct) begin
               acc_in   = acc_oct;
               phase_in = PH_OCT;
            end else begin
               emit        = 1'b1;
               emit_status = (phase_ff == PH_OCTF) ? ST_OCT_DIGIT : ST_OK;
            end
         end
      endcase
      if (emit) begin
         phase_in    = PH_IDLE;
         negative_in = 1'b0;
         acc_in      = '0;
         kind_in     = KIND_UNSIGNED;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      value_in     = value_ff;
      status_in    = status_ff;
      end_char_in  = end_char_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
         value_in     = (emit_status == ST_OK) ? 64'(signed'(mag)) : '0;
         status_in    = emit_status;
         end_char_in  = req_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         negative_ff  <= 1'b0;
         acc_ff       <= '0;
         kind_ff      <= KIND_UNSIGNED;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            negative_ff <= negative_in;
            acc_ff      <= acc_in;
            kind_ff     <= kind_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff    <= value_in;
      status_ff   <= status_in;
      end_char_ff <= end_char_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = value_ff;
   assign rsp_status   = status_ff;
   assign rsp_end_char = end_char_ff;

`ifndef NO_ASSERTIONS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_OK |-> value_ff == '0)
      else $error("error word carries nonzero value");

   a_sign_kind: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SIGN |-> kind_ff != KIND_UNSIGNED)
      else $error("sign phase on unsigned kind");

   a_zero_acc: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ZERO || phase_ff == PH_HEXF || phase_ff == PH_OCTF |-> acc_ff == '0)
      else $error("accumulator nonzero after leading zero");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !negative_ff && acc_ff == '0)
      else $error("state not cleared in idle");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !(accept && emit) |=> !rsp_valid_ff)
      else $error("result word repeated");
`endif

endmodule

`default_nettype wire
